// ===== rtl/core/fcz_pkg.sv =====
// Shared types and constants for the zero-edge FIR correlator.
package fcz_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int PROD_W    = 32;
  localparam int VALUE_W   = 34;
  localparam int RES_W     = 3;
  localparam int CFG_IDX_W = 3;

  // One input transaction
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       final_sample;
  } item_t;

  // One output transaction
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      run_last;
    logic                      block_last;
  } result_t;

  // Work descriptor passed from the front end to the back end
  typedef struct packed {
    logic             has_sum;
    logic [RES_W-1:0] count;
    logic             fin;
  } desc_t;

endpackage

// ===== rtl/core/fcz_front.sv =====
// Front end: tap registers, sample window, result classification and tap products.
module fcz_front #(
  parameter int TAPS = 7
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         item_valid,
  output logic                                         item_ready,
  input  fcz_pkg::item_t                               item,
  input  logic                                         cfg_we,
  input  logic [fcz_pkg::CFG_IDX_W-1:0]                cfg_index,
  input  logic [fcz_pkg::SAMPLE_W-1:0]                 cfg_data,
  output logic                                         push_valid,
  input  logic                                         push_ready,
  output fcz_pkg::desc_t                               push_desc,
  output logic [TAPS-1:0][fcz_pkg::PROD_W-1:0]         push_prod
);
  import fcz_pkg::*;

  localparam int HALF   = (TAPS - 1) / 2;
  localparam int HIST   = 2 * HALF;
  localparam int CNT_W  = $clog2(HIST + 1);
  localparam int TIDX_W = $clog2(TAPS);

  logic signed [SAMPLE_W-1:0] taps [TAPS];
  logic signed [SAMPLE_W-1:0] win [HIST];
  logic [CNT_W-1:0]           count;

  logic             accept;
  logic             below_half;
  logic             full;
  logic [RES_W-1:0] base;
  logic [RES_W-1:0] zeros;
  logic [RES_W-1:0] total;

  // Write tap registers; indexes past the kernel are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < TAPS; k++) taps[k] <= '0;
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(TAPS))) begin
      taps[cfg_index[TIDX_W-1:0]] <= cfg_data;
    end
  end

  assign accept     = item_valid && item_ready;
  assign item_ready = push_ready;

  // Classify the sample by its place in the block
  always_comb begin
    below_half = count < CNT_W'(HALF);
    full       = count == CNT_W'(HIST);
    base       = (below_half || full) ? RES_W'(1) : '0;
    zeros      = '0;
    if (item.final_sample) begin
      if (full) begin
        zeros = RES_W'(HALF);
      end else if (!below_half) begin
        zeros = RES_W'(count) + RES_W'(1) - RES_W'(HALF);
      end
    end
    total = base + zeros;
  end

  assign push_valid        = item_valid && (total != '0);
  assign push_desc.has_sum = full;
  assign push_desc.count   = total;
  assign push_desc.fin     = item.final_sample;

  // Form one product per tap; tap 0 weights the oldest sample
  for (genvar j = 0; j < TAPS; j++) begin : g_prod
    logic signed [PROD_W-1:0] xs;
    logic signed [PROD_W-1:0] ts;
    if (j < HIST) begin : g_hist
      assign xs = PROD_W'(win[HIST-1-j]);
    end else begin : g_new
      assign xs = PROD_W'(item.sample);
    end
    assign ts           = PROD_W'(taps[j]);
    assign push_prod[j] = xs * ts;
  end

  // Advance the window and the sample count; clear both at end of block
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      for (int k = 0; k < HIST; k++) win[k] <= '0;
    end else if (accept) begin
      if (item.final_sample) begin
        count <= '0;
        for (int k = 0; k < HIST; k++) win[k] <= '0;
      end else begin
        if (count < CNT_W'(HIST)) count <= count + CNT_W'(1);
        for (int k = HIST - 1; k > 0; k--) win[k] <= win[k-1];
        win[0] <= item.sample;
      end
    end
  end

  // Sample count saturates at the window history length
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(HIST))
    else $error("sample count past window history");

  // A pushed descriptor never asks for more results than one sum plus the trailing zeros
  assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (push_desc.count <= RES_W'(HALF + 1)))
    else $error("descriptor result count out of range");

endmodule

// ===== rtl/core/fcz_fifo.sv =====
// Small register queue between the front end and the back end.
module fcz_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             push;
  logic             pop;

  assign wr_ready = fill != CW'(DEPTH);
  assign rd_valid = fill != '0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  // Store entries
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (push && !pop) fill <= fill + CW'(1);
      else if (pop && !push) fill <= fill - CW'(1);
    end
  end

endmodule

// ===== rtl/core/fcz_back.sv =====
// Back end: sums tap products and expands each descriptor into its results.
module fcz_back #(
  parameter int TAPS = 7
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pop_valid,
  output logic                                 pop_ready,
  input  fcz_pkg::desc_t                       pop_desc,
  input  logic [TAPS-1:0][fcz_pkg::PROD_W-1:0] pop_prod,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output fcz_pkg::result_t                     result
);
  import fcz_pkg::*;

  logic signed [VALUE_W-1:0] value;
  logic [RES_W-1:0]          remaining;
  logic                      fin;
  logic                      busy;
  logic                      take;
  logic                      last;
  logic signed [VALUE_W-1:0] acc;

  assign last = remaining == RES_W'(1);
  assign take = result_valid && result_ready;

  // Load a new descriptor when idle or when the current one ends this cycle
  assign pop_ready = !busy || (take && last);

  // Sum the products at full precision
  always_comb begin
    acc = '0;
    for (int j = 0; j < TAPS; j++) begin
      acc = acc + VALUE_W'($signed(pop_prod[j]));
    end
  end

  // Hold the current result; later results of one descriptor are zeros
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      value <= pop_desc.has_sum ? acc : '0;
      fin   <= pop_desc.fin;
    end else if (take) begin
      value <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      remaining <= '0;
    end else if (pop_valid && pop_ready) begin
      busy      <= 1'b1;
      remaining <= pop_desc.count;
    end else if (take) begin
      busy      <= !last;
      remaining <= remaining - RES_W'(1);
    end
  end

  assign result_valid      = busy;
  assign result.value      = value;
  assign result.run_last   = last;
  assign result.block_last = last && fin;

  // A busy back end always has results left to give
  assert property (@(posedge clk) disable iff (rst) busy |-> (remaining != '0))
    else $error("back end busy with no results left");

  // Results after the first one of a descriptor are zeros
  assert property (@(posedge clk) disable iff (rst)
    (take && !last) |=> (result_valid && (result.value == '0)))
    else $error("trailing result is not zero");

endmodule

// ===== rtl/core/fir_correlate_zero_edges_unit.sv =====
// Top level of the streaming zero-edge FIR correlator.
//
//  channel   direction  handshake                 payload
//  item      in         item_valid / item_ready    fcz_pkg::item_t
//  result    out        result_valid / result_ready fcz_pkg::result_t
//  config    in         cfg_we                     cfg_index, cfg_data
//
// Takes one sample per cycle while the queue has room; a sample's sum is loaded into
// the result register as it leaves the queue (multiply before the queue, sum after
// it). With result_ready high, non-final samples (at most one result each) run at
// one sample per cycle; a final sample gives up to (TAPS+1)/2 results, one per cycle.
// Reset (rst, synchronous) clears taps, window, count, queue and pending results.
// Each side stalls on its own: the two-entry queue absorbs back-end stalls.
module fir_correlate_zero_edges_unit #(
  parameter int TAPS = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  fcz_pkg::item_t                item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output fcz_pkg::result_t              result,
  input  logic                          cfg_we,
  input  logic [fcz_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fcz_pkg::SAMPLE_W-1:0]  cfg_data
);
  import fcz_pkg::*;

  localparam int ENTRY_W = $bits(desc_t) + TAPS * PROD_W;

  logic                         push_valid;
  logic                         push_ready;
  desc_t                        push_desc;
  logic [TAPS-1:0][PROD_W-1:0]  push_prod;
  logic                         pop_valid;
  logic                         pop_ready;
  desc_t                        pop_desc;
  logic [TAPS-1:0][PROD_W-1:0]  pop_prod;
  logic [ENTRY_W-1:0]           wr_entry;
  logic [ENTRY_W-1:0]           rd_entry;

  // Accept and classify samples
  fcz_front #(.TAPS(TAPS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_desc  (push_desc),
    .push_prod  (push_prod)
  );

  assign wr_entry = {push_desc, push_prod};
  assign {pop_desc, pop_prod} = rd_entry;

  // Decouple front and back
  fcz_fifo #(.WIDTH(ENTRY_W), .DEPTH(2)) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (wr_entry),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_data  (rd_entry)
  );

  // Sum and emit results
  fcz_back #(.TAPS(TAPS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_desc     (pop_desc),
    .pop_prod     (pop_prod),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
